// ----- rtl/hdsu_pkg.sv -----
// Package with shared types and constants of the Huffman delta sample unpacker.
package hdsu_pkg;

  localparam int TREE_NODES  = 256;
  localparam int TREE_AW     = $clog2(TREE_NODES);
  localparam int STACK_DEPTH = 128;
  localparam int STACK_AW    = $clog2(STACK_DEPTH);
  localparam int VALUE_BITS  = 7;
  localparam int CHILD_W     = 9;
  localparam int COUNT_W     = 24;

  localparam logic [CHILD_W-1:0] NO_BRANCH  = 9'h1FF;
  localparam logic [CHILD_W-1:0] UNFOLLOWED = 9'h1FE;
  localparam logic [7:0]         SIGN_MASK  = 8'hFF;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_UNDERRUN  = 2'd1,
    STATUS_MALFORMED = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    PH_VALUE = 3'd0,
    PH_LEFT  = 3'd1,
    PH_RIGHT = 3'd2,
    PH_SIGN  = 3'd3,
    PH_WALK  = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_BIT,
    S_RESOLVE,
    S_POP,
    S_POPN,
    S_FETCH,
    S_END
  } state_e;

  typedef struct packed {
    logic [VALUE_BITS-1:0] val;
    logic [CHILD_W-1:0]    left;
    logic [CHILD_W-1:0]    right;
  } tree_entry_t;

  typedef struct packed {
    logic              we;
    logic [TREE_AW-1:0] waddr;
    tree_entry_t       wdata;
    logic              re;
    logic [TREE_AW-1:0] raddr;
  } tree_req_t;

  typedef struct packed {
    logic                we;
    logic [STACK_AW-1:0] waddr;
    logic [TREE_AW-1:0]  wdata;
    logic                re;
    logic [STACK_AW-1:0] raddr;
  } stack_req_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] value;
    logic       last;
    status_e    status;
  } emit_t;

endpackage

// ----- rtl/hdsu_in_if.sv -----
// Request channel carrying packed stream bytes.
interface hdsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] packed_byte;
  logic       last_byte;
  modport source (output valid, output packed_byte, output last_byte, input ready);
  modport sink (input valid, input packed_byte, input last_byte, output ready);
endinterface

// ----- rtl/hdsu_out_if.sv -----
// Request channel carrying decoded samples and status.
interface hdsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] sample_value;
  logic       is_last;
  logic [1:0] status;
  modport source (output valid, output sample_value, output is_last, output status,
                  input ready);
  modport sink (input valid, input sample_value, input is_last, input status,
                output ready);
endinterface

// ----- rtl/hdsu_cfg_if.sv -----
// Configuration write channel for the sample count register.
interface hdsu_cfg_if;
  logic        valid;
  logic        ready;
  logic [23:0] sample_count;
  modport source (output valid, output sample_count, input ready);
  modport sink (input valid, input sample_count, output ready);
endinterface

// ----- rtl/hdsu_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
module hdsu_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/hdsu_ctrl.sv -----
// Bit-serial sequencer: tree rebuild, backtracking and sample walk over the RAMs.
module hdsu_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic [7:0]                    in_byte_i,
  input  logic                          in_last_i,
  output logic                          in_ready_o,
  input  logic [hdsu_pkg::COUNT_W-1:0]  sample_count_i,
  input  logic                          slot_free_i,
  output hdsu_pkg::emit_t               emit_o,
  output hdsu_pkg::tree_req_t           tree_req_o,
  input  hdsu_pkg::tree_entry_t         tree_rdata_i,
  output hdsu_pkg::stack_req_t          stack_req_o,
  input  logic [hdsu_pkg::TREE_AW-1:0]  stack_rdata_i
);

  hdsu_pkg::state_e st_q, st_d;
  hdsu_pkg::phase_e ph_q, ph_d;
  logic [7:0] byte_q, byte_d;
  logic last_q, last_d;
  logic [2:0] bit_q, bit_d;
  logic [hdsu_pkg::STACK_AW:0] lvl_q, lvl_d;
  logic [hdsu_pkg::TREE_AW-1:0] cur_q, cur_d;
  logic [hdsu_pkg::TREE_AW:0] free_q, free_d;
  logic [hdsu_pkg::VALUE_BITS-1:0] vb_q, vb_d;
  logic [2:0] vc_q, vc_d;
  logic sign_q, sign_d;
  logic [7:0] total_q, total_d;
  logic [hdsu_pkg::COUNT_W-1:0] done_q, done_d;
  logic fin_q, fin_d;
  hdsu_pkg::tree_entry_t ent_q, ent_d;

  logic b;
  logic [hdsu_pkg::CHILD_W-1:0] nx;
  logic [7:0] leaf_v;
  logic [7:0] sum;
  logic [hdsu_pkg::COUNT_W-1:0] done_inc;
  logic stall;
  logic to_end;

  assign b        = byte_q[bit_q];
  assign nx       = b ? ent_q.right : ent_q.left;
  assign leaf_v   = {1'b0, tree_rdata_i.val} ^ (sign_q ? hdsu_pkg::SIGN_MASK : 8'h00);
  assign sum      = total_q + leaf_v;
  assign done_inc = done_q + 1'b1;
  assign to_end   = (bit_q == 3'd7);
  assign in_ready_o = (st_q == hdsu_pkg::S_IDLE);

  always_comb begin
    st_d = st_q; ph_d = ph_q; byte_d = byte_q; last_d = last_q; bit_d = bit_q;
    lvl_d = lvl_q; cur_d = cur_q; free_d = free_q; vb_d = vb_q; vc_d = vc_q;
    sign_d = sign_q; total_d = total_q; done_d = done_q; fin_d = fin_q; ent_d = ent_q;
    emit_o = '0;
    emit_o.status = hdsu_pkg::STATUS_OK;
    tree_req_o = '0;
    stack_req_o = '0;

    case (st_q)
      hdsu_pkg::S_IDLE: begin
        if (in_valid_i) begin
          byte_d = in_byte_i;
          last_d = in_last_i;
          bit_d  = 3'd0;
          st_d   = hdsu_pkg::S_CHECK;
        end
      end
      hdsu_pkg::S_CHECK: begin
        if (!fin_q && ph_q == hdsu_pkg::PH_SIGN && done_q >= sample_count_i) begin
          emit_o.valid = 1'b1;
          emit_o.last  = 1'b1;
          fin_d = 1'b1;
          st_d  = hdsu_pkg::S_END;
        end else begin
          st_d = fin_q ? hdsu_pkg::S_END : hdsu_pkg::S_BIT;
        end
      end
      hdsu_pkg::S_BIT: begin
        // Bits that finish in a later state advance the bit index there.
        st_d  = to_end ? hdsu_pkg::S_END : hdsu_pkg::S_BIT;
        case (ph_q)
          hdsu_pkg::PH_VALUE: begin
            bit_d = bit_q + 3'd1;
            vb_d = vb_q | (hdsu_pkg::VALUE_BITS'(b) << vc_q);
            vc_d = vc_q + 3'd1;
            if (vc_q == 3'(hdsu_pkg::VALUE_BITS - 1)) begin
              ent_d.val = vb_d;
              ph_d = hdsu_pkg::PH_LEFT;
            end
          end
          hdsu_pkg::PH_LEFT: begin
            bit_d = bit_q + 3'd1;
            ent_d.left = b ? hdsu_pkg::UNFOLLOWED : hdsu_pkg::NO_BRANCH;
            ph_d = hdsu_pkg::PH_RIGHT;
          end
          hdsu_pkg::PH_RIGHT: begin
            ent_d.right = b ? hdsu_pkg::UNFOLLOWED : hdsu_pkg::NO_BRANCH;
            st_d = hdsu_pkg::S_RESOLVE;
          end
          hdsu_pkg::PH_SIGN: begin
            sign_d = b;
            cur_d  = '0;
            ph_d   = hdsu_pkg::PH_WALK;
            tree_req_o.re = 1'b1;
            tree_req_o.raddr = '0;
            st_d = hdsu_pkg::S_FETCH;
          end
          default: begin
            if (nx[hdsu_pkg::TREE_AW]) begin
              emit_o.valid  = 1'b1;
              emit_o.last   = 1'b1;
              emit_o.status = hdsu_pkg::STATUS_MALFORMED;
              fin_d = 1'b1;
              st_d  = hdsu_pkg::S_END;
            end else begin
              cur_d = nx[hdsu_pkg::TREE_AW-1:0];
              tree_req_o.re = 1'b1;
              tree_req_o.raddr = nx[hdsu_pkg::TREE_AW-1:0];
              st_d = hdsu_pkg::S_FETCH;
            end
          end
        endcase
      end
      hdsu_pkg::S_FETCH: begin
        // Entry of the node just stepped to is on the read port now.
        ent_d = tree_rdata_i;
        bit_d = bit_q + 3'd1;
        st_d  = to_end ? hdsu_pkg::S_END : hdsu_pkg::S_BIT;
        if (tree_rdata_i.left == hdsu_pkg::NO_BRANCH &&
            tree_rdata_i.right == hdsu_pkg::NO_BRANCH) begin
          total_d = sum;
          done_d  = done_inc;
          ph_d    = hdsu_pkg::PH_SIGN;
          emit_o.valid = 1'b1;
          emit_o.value = sum;
          if (done_inc >= sample_count_i) begin
            emit_o.last = 1'b1;
            fin_d = 1'b1;
            st_d  = hdsu_pkg::S_END;
          end
        end
      end
      hdsu_pkg::S_RESOLVE: begin
        tree_req_o.we    = 1'b1;
        tree_req_o.waddr = cur_q;
        tree_req_o.wdata = ent_q;
        if (ent_q.left == hdsu_pkg::UNFOLLOWED || ent_q.right == hdsu_pkg::UNFOLLOWED) begin
          if (lvl_q >= (hdsu_pkg::STACK_AW+1)'(hdsu_pkg::STACK_DEPTH) ||
              free_q >= (hdsu_pkg::TREE_AW+1)'(hdsu_pkg::TREE_NODES)) begin
            emit_o.valid  = 1'b1;
            emit_o.last   = 1'b1;
            emit_o.status = hdsu_pkg::STATUS_MALFORMED;
            fin_d = 1'b1;
            st_d  = hdsu_pkg::S_END;
          end else begin
            if (ent_q.left == hdsu_pkg::UNFOLLOWED) begin
              tree_req_o.wdata.left = {1'b0, free_q[hdsu_pkg::TREE_AW-1:0]};
            end else begin
              tree_req_o.wdata.right = {1'b0, free_q[hdsu_pkg::TREE_AW-1:0]};
            end
            stack_req_o.we    = 1'b1;
            stack_req_o.waddr = lvl_q[hdsu_pkg::STACK_AW-1:0];
            stack_req_o.wdata = cur_q;
            lvl_d  = lvl_q + 1'b1;
            cur_d  = free_q[hdsu_pkg::TREE_AW-1:0];
            free_d = free_q + 1'b1;
            ph_d   = hdsu_pkg::PH_VALUE;
            vb_d   = '0;
            vc_d   = '0;
            bit_d  = bit_q + 3'd1;
            st_d   = to_end ? hdsu_pkg::S_END : hdsu_pkg::S_BIT;
          end
        end else if (lvl_q == '0) begin
          ph_d  = hdsu_pkg::PH_SIGN;
          bit_d = bit_q + 3'd1;
          st_d  = to_end ? hdsu_pkg::S_END : hdsu_pkg::S_BIT;
          if (done_q >= sample_count_i) begin
            emit_o.valid = 1'b1;
            emit_o.last  = 1'b1;
            fin_d = 1'b1;
            st_d  = hdsu_pkg::S_END;
          end
        end else begin
          lvl_d = lvl_q - 1'b1;
          stack_req_o.re    = 1'b1;
          stack_req_o.raddr = lvl_d[hdsu_pkg::STACK_AW-1:0];
          st_d = hdsu_pkg::S_POP;
        end
      end
      hdsu_pkg::S_POP: begin
        cur_d = stack_rdata_i;
        tree_req_o.re    = 1'b1;
        tree_req_o.raddr = stack_rdata_i;
        st_d = hdsu_pkg::S_POPN;
      end
      hdsu_pkg::S_POPN: begin
        ent_d = tree_rdata_i;
        st_d  = hdsu_pkg::S_RESOLVE;
      end
      hdsu_pkg::S_END: begin
        st_d = hdsu_pkg::S_IDLE;
        if (last_q) begin
          if (!fin_q) begin
            emit_o.valid  = 1'b1;
            emit_o.last   = 1'b1;
            emit_o.status = hdsu_pkg::STATUS_UNDERRUN;
          end
          lvl_d = '0; cur_d = '0; free_d = (hdsu_pkg::TREE_AW+1)'(1);
          ph_d = hdsu_pkg::PH_VALUE; vb_d = '0; vc_d = '0; sign_d = 1'b0;
          total_d = '0; done_d = '0; fin_d = 1'b0;
        end
      end
      default: begin
        st_d = hdsu_pkg::S_IDLE;
      end
    endcase

    // A result with no free output slot holds the whole step.
    stall = emit_o.valid && !slot_free_i;
    if (stall) begin
      st_d = st_q; ph_d = ph_q; byte_d = byte_q; last_d = last_q; bit_d = bit_q;
      lvl_d = lvl_q; cur_d = cur_q; free_d = free_q; vb_d = vb_q; vc_d = vc_q;
      sign_d = sign_q; total_d = total_q; done_d = done_q; fin_d = fin_q; ent_d = ent_q;
      emit_o.valid = 1'b0;
      tree_req_o.we = 1'b0;
      tree_req_o.re = 1'b0;
      stack_req_o.we = 1'b0;
      stack_req_o.re = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= hdsu_pkg::S_IDLE;
      ph_q <= hdsu_pkg::PH_VALUE;
      last_q <= 1'b0;
      bit_q <= '0;
      lvl_q <= '0;
      cur_q <= '0;
      free_q <= (hdsu_pkg::TREE_AW+1)'(1);
      vb_q <= '0;
      vc_q <= '0;
      sign_q <= 1'b0;
      total_q <= '0;
      done_q <= '0;
      fin_q <= 1'b0;
    end else begin
      st_q <= st_d;
      ph_q <= ph_d;
      last_q <= last_d;
      bit_q <= bit_d;
      lvl_q <= lvl_d;
      cur_q <= cur_d;
      free_q <= free_d;
      vb_q <= vb_d;
      vc_q <= vc_d;
      sign_q <= sign_d;
      total_q <= total_d;
      done_q <= done_d;
      fin_q <= fin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    ent_q  <= ent_d;
  end

  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lvl_q <= (hdsu_pkg::STACK_AW+1)'(hdsu_pkg::STACK_DEPTH))
    else $error("stack level beyond depth");
  a_node_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= (hdsu_pkg::TREE_AW+1)'(hdsu_pkg::TREE_NODES))
    else $error("node allocation beyond tree size");
  a_emit_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_o.valid |-> slot_free_i)
    else $error("result emitted with a full output slot");
  a_quiet_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q |-> !emit_o.valid)
    else $error("result after the block ended");

endmodule

// ----- rtl/huffman_delta_sample_unpacker.sv -----
// Top level of the Huffman delta sample unpacker.
// The block reads packed bytes one at a time, least significant bit first, rebuilds
// the preorder Huffman tree sent at the head of each block, and then decodes one
// sample per sign bit plus tree walk, emitting the running 8-bit delta total.
// Each byte is accepted, passes a count check and closes with an end step. A node
// value or left-presence bit is taken in the bit loop itself; a right-presence bit
// also has the node written back and resolved, each sign or walk bit waits for the
// tree RAM read of the walk, and each backtrack pop while the tree is rebuilt reads
// the stack RAM, then the tree RAM. A new byte is taken only after the previous one
// is fully handled.
// The result register holds one finished result while the sequencer works on; when
// it is still full and a new result appears, the sequencer waits. Status results
// carry a zero sample value and end the block: status 1 when the byte marked last
// runs out before the count, status 2 for a malformed tree. Bytes that arrive after
// the block ended are dropped until the marked last byte. The sample count is
// written through the configuration channel, which is always ready and should only
// be used while the block is idle.
module huffman_delta_sample_unpacker (
  input  logic    clk_i,
  input  logic    rst_ni,
  hdsu_in_if.sink   in_i,
  hdsu_cfg_if.sink  cfg_i,
  hdsu_out_if.source out_o
);

  logic [hdsu_pkg::COUNT_W-1:0] sample_count_q;
  logic                         out_valid_q;
  logic [7:0]                   out_value_q;
  logic                         out_last_q;
  hdsu_pkg::status_e            out_status_q;
  logic                         slot_free;
  hdsu_pkg::emit_t              emit;
  hdsu_pkg::tree_req_t          tree_req;
  hdsu_pkg::tree_entry_t        tree_rdata;
  hdsu_pkg::stack_req_t         stack_req;
  logic [hdsu_pkg::TREE_AW-1:0] stack_rdata;
  logic                         in_ready;

  assign cfg_i.ready = 1'b1;

  // Sample count register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_count_q <= '0;
    end else if (cfg_i.valid) begin
      sample_count_q <= cfg_i.sample_count;
    end
  end

  // One-entry result register between the sequencer and the output channel.
  assign slot_free = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit.valid) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit.valid) begin
      out_value_q  <= emit.value;
      out_last_q   <= emit.last;
      out_status_q <= emit.status;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.sample_value = out_value_q;
  assign out_o.is_last      = out_last_q;
  assign out_o.status       = out_status_q;
  assign in_i.ready         = in_ready;

  hdsu_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_i.valid),
    .in_byte_i      (in_i.packed_byte),
    .in_last_i      (in_i.last_byte),
    .in_ready_o     (in_ready),
    .sample_count_i (sample_count_q),
    .slot_free_i    (slot_free),
    .emit_o         (emit),
    .tree_req_o     (tree_req),
    .tree_rdata_i   (tree_rdata),
    .stack_req_o    (stack_req),
    .stack_rdata_i  (stack_rdata)
  );

  // Tree memory: node value and both child codes in one word per node.
  hdsu_ram #(
    .DEPTH (hdsu_pkg::TREE_NODES),
    .WIDTH ($bits(hdsu_pkg::tree_entry_t))
  ) u_tree_ram (
    .clk_i   (clk_i),
    .we_i    (tree_req.we),
    .waddr_i (tree_req.waddr),
    .wdata_i (tree_req.wdata),
    .re_i    (tree_req.re),
    .raddr_i (tree_req.raddr),
    .rdata_o (tree_rdata)
  );

  // Backtrack stack of parent node numbers.
  hdsu_ram #(
    .DEPTH (hdsu_pkg::STACK_DEPTH),
    .WIDTH (hdsu_pkg::TREE_AW)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stack_req.we),
    .waddr_i (stack_req.waddr),
    .wdata_i (stack_req.wdata),
    .re_i    (stack_req.re),
    .raddr_i (stack_req.raddr),
    .rdata_o (stack_rdata)
  );

endmodule

// ----- sim/tb_huffman_delta_sample_unpacker.sv -----
// Testbench for the Huffman delta sample unpacker: generated streams checked against a predictor.
`timescale 1ns / 100ps

module tb_huffman_delta_sample_unpacker;

  localparam int IDLE_LIMIT  = 40000;
  localparam int SETTLE_CYC  = 64;
  localparam int RAND_ITEMS  = 310;

  typedef struct {
    logic [7:0]        value;
    logic              last;
    hdsu_pkg::status_e status;
  } sample_t;

  // One row of the directed table; typed rows carry their results.
  typedef struct {
    bit          cfg_en;
    logic [23:0] cfg_val;
    logic [7:0]  data;
    logic        lst;
    bit          typed;
    int          n;
    sample_t     r0;
    sample_t     r1;
  } row_t;

  logic clk;
  logic rst_n;

  hdsu_in_if  in_if();
  hdsu_cfg_if cfg_if();
  hdsu_out_if out_if();

  huffman_delta_sample_unpacker dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .cfg_i (cfg_if),
    .out_o (out_if)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Results still owed by the block, oldest first.
  sample_t pending_samples[$];
  int      mismatches;
  int      results_seen;
  int      bytes_sent;
  int      blocks_sent;
  bit      calm;

  // Predictor state, a private copy of the block's decoder.
  logic [6:0]  pr_val[hdsu_pkg::TREE_NODES];
  logic [8:0]  pr_left[hdsu_pkg::TREE_NODES];
  logic [8:0]  pr_right[hdsu_pkg::TREE_NODES];
  logic [7:0]  pr_stack[hdsu_pkg::STACK_DEPTH];
  logic [7:0]  pr_level;
  logic [7:0]  pr_cur;
  logic [8:0]  pr_next;
  hdsu_pkg::phase_e pr_phase;
  logic [6:0]  pr_vbits;
  logic [2:0]  pr_vcnt;
  logic        pr_sign;
  logic [7:0]  pr_total;
  logic [23:0] pr_done;
  logic        pr_fin;
  logic [23:0] pr_count;

  task automatic expect_sample(logic [7:0] v, logic l, hdsu_pkg::status_e s);
    sample_t e;
    e.value = v;
    e.last = l;
    e.status = s;
    pending_samples.push_back(e);
  endtask

  task automatic end_block(hdsu_pkg::status_e s);
    expect_sample(8'h00, 1'b1, s);
    pr_fin = 1'b1;
  endtask

  task automatic block_restart();
    pr_level = '0;
    pr_cur = '0;
    pr_next = 9'd1;
    pr_phase = hdsu_pkg::PH_VALUE;
    pr_vbits = '0;
    pr_vcnt = '0;
    pr_sign = 1'b0;
    pr_total = '0;
    pr_done = '0;
    pr_fin = 1'b0;
  endtask

  task automatic count_check();
    if (!pr_fin && pr_phase == hdsu_pkg::PH_SIGN && pr_done >= pr_count)
      end_block(hdsu_pkg::STATUS_OK);
  endtask

  function automatic bit node_is_leaf(logic [7:0] nd);
    return pr_left[nd] == hdsu_pkg::NO_BRANCH && pr_right[nd] == hdsu_pkg::NO_BRANCH;
  endfunction

  task automatic leaf_hit();
    logic [7:0] v;
    v = {1'b0, pr_val[pr_cur]};
    if (pr_sign) v = v ^ hdsu_pkg::SIGN_MASK;
    pr_total = pr_total + v;
    pr_done = pr_done + 1'b1;
    pr_phase = hdsu_pkg::PH_SIGN;
    if (pr_done >= pr_count) begin
      expect_sample(pr_total, 1'b1, hdsu_pkg::STATUS_OK);
      pr_fin = 1'b1;
    end else begin
      expect_sample(pr_total, 1'b0, hdsu_pkg::STATUS_OK);
    end
  endtask

  // After a node header: descend into the first unfollowed branch, or pop back up.
  task automatic follow_branches();
    bit busy;
    bit go_left;
    bit go_right;
    busy = 1'b1;
    while (busy) begin
      go_left = pr_left[pr_cur] == hdsu_pkg::UNFOLLOWED;
      go_right = !go_left && pr_right[pr_cur] == hdsu_pkg::UNFOLLOWED;
      if (go_left || go_right) begin
        busy = 1'b0;
        if (pr_level >= hdsu_pkg::STACK_DEPTH || pr_next >= hdsu_pkg::TREE_NODES) begin
          end_block(hdsu_pkg::STATUS_MALFORMED);
        end else begin
          pr_stack[pr_level[hdsu_pkg::STACK_AW-1:0]] = pr_cur;
          pr_level = pr_level + 1'b1;
          if (go_left) pr_left[pr_cur] = pr_next;
          else pr_right[pr_cur] = pr_next;
          pr_cur = pr_next[7:0];
          pr_next = pr_next + 1'b1;
          pr_phase = hdsu_pkg::PH_VALUE;
          pr_vbits = '0;
          pr_vcnt = '0;
        end
      end else if (pr_level == 0) begin
        busy = 1'b0;
        pr_phase = hdsu_pkg::PH_SIGN;
        count_check();
      end else begin
        pr_level = pr_level - 1'b1;
        pr_cur = pr_stack[pr_level[hdsu_pkg::STACK_AW-1:0]];
      end
    end
  endtask

  task automatic decode_bit(logic b);
    logic [8:0] nx;
    case (pr_phase)
      hdsu_pkg::PH_VALUE: begin
        pr_vbits[pr_vcnt] = b;
        pr_vcnt = pr_vcnt + 1'b1;
        if (pr_vcnt >= hdsu_pkg::VALUE_BITS) begin
          pr_val[pr_cur] = pr_vbits;
          pr_phase = hdsu_pkg::PH_LEFT;
        end
      end
      hdsu_pkg::PH_LEFT: begin
        pr_left[pr_cur] = b ? hdsu_pkg::UNFOLLOWED : hdsu_pkg::NO_BRANCH;
        pr_phase = hdsu_pkg::PH_RIGHT;
      end
      hdsu_pkg::PH_RIGHT: begin
        pr_right[pr_cur] = b ? hdsu_pkg::UNFOLLOWED : hdsu_pkg::NO_BRANCH;
        follow_branches();
      end
      hdsu_pkg::PH_SIGN: begin
        pr_sign = b;
        pr_cur = '0;
        pr_phase = hdsu_pkg::PH_WALK;
        if (node_is_leaf(8'd0)) leaf_hit();
      end
      default: begin
        nx = b ? pr_right[pr_cur] : pr_left[pr_cur];
        if (nx >= hdsu_pkg::TREE_NODES) begin
          end_block(hdsu_pkg::STATUS_MALFORMED);
        end else begin
          pr_cur = nx[7:0];
          if (node_is_leaf(pr_cur)) leaf_hit();
        end
      end
    endcase
  endtask

  task automatic decode_byte(logic [7:0] data, logic lst);
    count_check();
    for (int i = 0; i < 8 && !pr_fin; i++) decode_bit(data[i]);
    if (lst) begin
      if (!pr_fin) end_block(hdsu_pkg::STATUS_UNDERRUN);
      block_restart();
    end
  endtask

  // Sender: random gaps, then hold the request until the block takes it.
  // The predictor runs at the accepting edge.
  task automatic send_byte(logic [7:0] data, logic lst, bit typed = 1'b0, int n = 0,
                           sample_t r0 = '{value: '0, last: 1'b0,
                                           status: hdsu_pkg::STATUS_OK},
                           sample_t r1 = '{value: '0, last: 1'b0,
                                           status: hdsu_pkg::STATUS_OK});
    int before_n;
    while (!calm && $urandom_range(99) < 26) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid = 1'b1;
    in_if.packed_byte = data;
    in_if.last_byte = lst;
    do @(posedge clk); while (!in_if.ready);
    before_n = pending_samples.size();
    decode_byte(data, lst);
    if (typed) begin
      // The row states its own results; they replace what was just predicted.
      while (pending_samples.size() > before_n) void'(pending_samples.pop_back());
      if (n > 0) pending_samples.push_back(r0);
      if (n > 1) pending_samples.push_back(r1);
    end
    bytes_sent++;
    @(negedge clk);
    in_if.valid = 1'b0;
  endtask

  // Pause the sender until every owed result has arrived and the block has settled.
  task automatic drain();
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_count(logic [23:0] v);
    drain();
    cfg_if.valid = 1'b1;
    cfg_if.sample_count = v;
    do @(posedge clk); while (!cfg_if.ready);
    pr_count = v;
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // Stream builder: bits are collected first, then packed lsb first into bytes.
  bit bit_stream[$];
  int gen_left[hdsu_pkg::TREE_NODES + 8];
  int gen_right[hdsu_pkg::TREE_NODES + 8];
  int gen_nodes;

  localparam int TREE_RANDOM = 0;
  localparam int TREE_FULL   = 1;
  localparam int TREE_CHAIN  = 2;

  function automatic int grow_tree(int depth, int max_depth, int max_nodes, int shape);
    int nd;
    int pick;
    bit hl;
    bit hr;
    nd = gen_nodes;
    gen_nodes++;
    gen_left[nd] = -1;
    gen_right[nd] = -1;
    for (int i = 0; i < hdsu_pkg::VALUE_BITS; i++) bit_stream.push_back($urandom_range(1));
    hl = 1'b0;
    hr = 1'b0;
    if (depth < max_depth && gen_nodes < max_nodes) begin
      if (shape == TREE_FULL) begin
        hl = 1'b1;
        hr = 1'b1;
      end else if (shape == TREE_CHAIN) begin
        hl = 1'b1;
      end else begin
        pick = $urandom_range(99);
        hl = pick < 75;
        hr = pick < 60 || pick >= 90;
      end
    end
    bit_stream.push_back(hl);
    bit_stream.push_back(hr);
    if (hl) gen_left[nd] = grow_tree(depth + 1, max_depth, max_nodes, shape);
    if (hr) gen_right[nd] = grow_tree(depth + 1, max_depth, max_nodes, shape);
    return nd;
  endfunction

  // One coded sample; now and then it takes a missing branch on purpose.
  function automatic void add_sample();
    int nd;
    bit dir;
    nd = 0;
    bit_stream.push_back($urandom_range(1));
    while (gen_left[nd] >= 0 || gen_right[nd] >= 0) begin
      if (gen_left[nd] >= 0 && gen_right[nd] >= 0) dir = $urandom_range(1);
      else dir = gen_right[nd] >= 0;
      if ($urandom_range(99) < 2) dir = ~dir;
      bit_stream.push_back(dir);
      if ((dir ? gen_right[nd] : gen_left[nd]) < 0) return;
      nd = dir ? gen_right[nd] : gen_left[nd];
    end
  endfunction

  task automatic send_stream(int extra_bytes);
    logic [7:0] data;
    while (bit_stream.size() != 0 || extra_bytes > 0) begin
      data = $urandom_range(255);
      if (bit_stream.size() == 0) extra_bytes--;
      for (int i = 0; i < 8 && bit_stream.size() != 0; i++) data[i] = bit_stream.pop_front();
      send_byte(data, bit_stream.size() == 0 && extra_bytes == 0);
    end
    blocks_sent++;
  endtask

  // Directed table: typed rows have results read straight off the stream layout.
  row_t rows[$];

  function automatic sample_t smp(logic [7:0] v, logic l, hdsu_pkg::status_e s);
    sample_t e;
    e.value = v;
    e.last = l;
    e.status = s;
    return e;
  endfunction

  function automatic row_t mk_row(bit ce, logic [23:0] cv, logic [7:0] d, logic l, bit t,
                                  int n, sample_t a, sample_t b);
    row_t r;
    r.cfg_en = ce;
    r.cfg_val = cv;
    r.data = d;
    r.lst = l;
    r.typed = t;
    r.n = n;
    r.r0 = a;
    r.r1 = b;
    return r;
  endfunction

  // Output side: random back-pressure and the comparison with the oldest expectation.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_if.ready = calm || $urandom_range(99) >= 26;
    end
  end

  always @(posedge clk) begin
    sample_t e;
    if (rst_n && out_if.valid && out_if.ready) begin
      results_seen++;
      if (pending_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: value %h last %b status %0d", out_if.sample_value,
                   out_if.is_last, out_if.status);
      end else begin
        e = pending_samples.pop_front();
        if (out_if.sample_value !== e.value || out_if.is_last !== e.last ||
            out_if.status !== e.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected value %h last %b status %0d, got %h %b %0d",
                     e.value, e.last, e.status, out_if.sample_value, out_if.is_last,
                     out_if.status);
        end
      end
    end
  end

  // Watchdog on cycles in which no request moves on any channel.
  int idle_cycles;
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int shape;
    int nsamp;
    int cut;
    logic [23:0] cnt;
    sample_t none;
    none = smp(8'h00, 1'b0, hdsu_pkg::STATUS_OK);
    in_if.valid = 1'b0;
    in_if.packed_byte = '0;
    in_if.last_byte = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.sample_count = '0;
    calm = 1'b0;
    mismatches = 0;
    results_seen = 0;
    bytes_sent = 0;
    blocks_sent = 0;
    idle_cycles = 0;
    for (int i = 0; i < hdsu_pkg::TREE_NODES; i++) begin
      pr_left[i] = hdsu_pkg::NO_BRANCH;
      pr_right[i] = hdsu_pkg::NO_BRANCH;
      pr_val[i] = '0;
    end
    pr_count = '0;
    block_restart();
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Count of zero: a lone marked byte runs out inside the header.
    rows.push_back(mk_row(1, 24'd0, 8'h00, 1, 1, 1,
                          smp(8'h00, 1, hdsu_pkg::STATUS_UNDERRUN), none));
    // A single-leaf tree with count zero ends as soon as the header is complete.
    rows.push_back(mk_row(0, 24'd0, 8'h7F, 0, 1, 0, none, none));
    rows.push_back(mk_row(0, 24'd0, 8'h00, 1, 1, 1, smp(8'h00, 1, hdsu_pkg::STATUS_OK),
                          none));
    // Leaf 0x7F added plain and then inverted: totals 0x7F and 0xFF.
    rows.push_back(mk_row(1, 24'd2, 8'h7F, 0, 1, 0, none, none));
    rows.push_back(mk_row(0, 24'd2, 8'h04, 1, 1, 2, smp(8'h7F, 0, hdsu_pkg::STATUS_OK),
                          smp(8'hFF, 1, hdsu_pkg::STATUS_OK)));
    // Largest count; the root has no right child and the walk asks for it.
    rows.push_back(mk_row(1, 24'hFFFFFF, 8'hFF, 0, 1, 0, none, none));
    rows.push_back(mk_row(0, 24'hFFFFFF, 8'h00, 0, 1, 0, none, none));
    rows.push_back(mk_row(0, 24'hFFFFFF, 8'h08, 1, 1, 1,
                          smp(8'h00, 1, hdsu_pkg::STATUS_MALFORMED), none));
    rows.push_back(mk_row(1, 24'd5, 8'hA5, 0, 0, 0, none, none));
    rows.push_back(mk_row(0, 24'd5, 8'h5A, 0, 0, 0, none, none));
    rows.push_back(mk_row(0, 24'd5, 8'hFF, 0, 0, 0, none, none));
    rows.push_back(mk_row(0, 24'd5, 8'h33, 1, 0, 0, none, none));
    foreach (rows[i]) begin
      if (rows[i].cfg_en) write_count(rows[i].cfg_val);
      send_byte(rows[i].data, rows[i].lst, rows[i].typed, rows[i].n, rows[i].r0, rows[i].r1);
    end
    write_count(24'd1);

    // Random blocks: mostly well-formed trees and samples, some noise and cut streams.
    while (bytes_sent < RAND_ITEMS + rows.size()) begin
      calm = blocks_sent >= 8 && blocks_sent < 14;
      case ($urandom_range(9))
        0: cnt = 24'd0;
        1: cnt = 24'hFFFFFF;
        2: cnt = $urandom_range(24'hFFFFFF);
        default: cnt = $urandom_range(1, 12);
      endcase
      write_count(cnt);
      if ($urandom_range(99) < 15) begin
        repeat ($urandom_range(1, 6)) bit_stream.push_back($urandom_range(1));
        repeat ($urandom_range(0, 40)) bit_stream.push_back($urandom_range(1));
        send_stream(0);
      end else begin
        gen_nodes = 0;
        void'(grow_tree(0, $urandom_range(0, 5), 24, TREE_RANDOM));
        nsamp = (cnt > 16 ? 14 : int'(cnt)) + $urandom_range(4) - 2;
        for (int i = 0; i < nsamp; i++) add_sample();
        if ($urandom_range(99) < 10) begin
          cut = $urandom_range(bit_stream.size());
          while (bit_stream.size() > cut) void'(bit_stream.pop_back());
        end
        if ($urandom_range(99) < 12 && bit_stream.size() > 24) begin
          // Set a new count of 0 to 3 in the middle of the block, once the block is idle.
          for (int i = 0; i < 16; i++) bit_stream.push_back(1'b0);
          repeat (2) begin
            send_byte({bit_stream[7], bit_stream[6], bit_stream[5], bit_stream[4],
                       bit_stream[3], bit_stream[2], bit_stream[1], bit_stream[0]}, 1'b0);
            repeat (8) void'(bit_stream.pop_front());
          end
          write_count($urandom_range(3));
        end
        send_stream($urandom_range(2));
      end
    end

    // Node overflow: a full tree needs more nodes than the memory holds.
    write_count(24'd3);
    gen_nodes = 0;
    void'(grow_tree(0, 8, hdsu_pkg::TREE_NODES + 2, TREE_FULL));
    send_stream(0);
    // Stack overflow: a left-only chain deeper than the backtrack stack.
    write_count(24'd3);
    gen_nodes = 0;
    void'(grow_tree(0, hdsu_pkg::STACK_DEPTH + 2, hdsu_pkg::TREE_NODES, TREE_CHAIN));
    send_stream(0);

    drain();
    $display("Sent %0d bytes in %0d generated blocks plus the directed table;", bytes_sent,
             blocks_sent);
    $display("checked %0d results, %0d mismatches.", results_seen, mismatches);
    if (mismatches == 0 && pending_samples.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
